// ===== rtl/glyph_slot_cache_lru_unit_defines.svh =====
// assertion macros for the glyph slot cache
// used by the top level only, which supplies clk_i and rst_ni in scope
`ifndef GLYPH_SLOT_CACHE_LRU_UNIT_DEFINES_SVH
`define GLYPH_SLOT_CACHE_LRU_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define GSC_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("glyph slot cache check failed");
`define GSC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("glyph slot cache check failed");
`else
`define GSC_ASSERT_SAME(name, ante, cons)
`define GSC_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// ===== rtl/gsc_pkg.sv =====
// shared constants and types for the glyph slot cache
// no dependencies
package gsc_pkg;

  localparam int MAX_SLOTS_DEF = 64;
  localparam int CHAR_W        = 16;
  localparam int STAMP_W       = 16;
  localparam int CFG_W         = 7;
  localparam int OUT_SLOT_W    = 6;
  localparam int COUNT_W       = 8;
  localparam int MISS_W        = 32;

  localparam logic [CFG_W-1:0]   SLOTS_RESET = 7'd64;
  localparam logic [STAMP_W-1:0] STAMP_RESET = 16'd1;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'd255;

  typedef struct packed {
    logic start;
    logic step;
  } scan_ctrl_t;

endpackage

// ===== rtl/gsc_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module gsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gsc_scan.sv =====
// slot scan unit: one compare of key and stamp per step, keeps first hit and lowest stamp
// depends on gsc_pkg
module gsc_scan #(
  parameter int MAX_SLOTS = gsc_pkg::MAX_SLOTS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  gsc_pkg::scan_ctrl_t          ctrl_i,
  input  logic [$clog2(MAX_SLOTS)-1:0] idx_i,
  input  logic                         entry_valid_i,
  input  logic [gsc_pkg::CHAR_W-1:0]   entry_char_i,
  input  logic [gsc_pkg::STAMP_W-1:0]  entry_stamp_i,
  input  logic [gsc_pkg::CHAR_W-1:0]   key_i,
  output logic                         found_o,
  output logic [$clog2(MAX_SLOTS)-1:0] hit_idx_o,
  output logic [$clog2(MAX_SLOTS)-1:0] min_idx_o
);
  import gsc_pkg::*;

  localparam int SLOT_W = $clog2(MAX_SLOTS);

  logic               found_q, found_d;
  logic [SLOT_W-1:0]  hit_idx_q, hit_idx_d;
  logic [SLOT_W-1:0]  min_idx_q, min_idx_d;
  logic [STAMP_W-1:0] min_stamp_q, min_stamp_d;
  logic [STAMP_W-1:0] eff_stamp;
  logic               match;
  logic               take_min;

  // a slot never written reads as stamp zero
  assign eff_stamp = entry_valid_i ? entry_stamp_i : '0;
  assign match     = entry_valid_i && (entry_char_i == key_i);
  assign take_min  = (idx_i == SLOT_W'(1)) || (eff_stamp < min_stamp_q);

  always_comb begin
    found_d     = found_q;
    hit_idx_d   = hit_idx_q;
    min_idx_d   = min_idx_q;
    min_stamp_d = min_stamp_q;
    if (ctrl_i.start) begin
      found_d   = 1'b0;
      min_idx_d = SLOT_W'(1);
    end else if (ctrl_i.step) begin
      if (match && !found_q) begin
        found_d   = 1'b1;
        hit_idx_d = idx_i;
      end
      if (take_min) begin
        min_idx_d   = idx_i;
        min_stamp_d = eff_stamp;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q   <= 1'b0;
      min_idx_q <= SLOT_W'(1);
    end else begin
      found_q   <= found_d;
      min_idx_q <= min_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q   <= hit_idx_d;
    min_stamp_q <= min_stamp_d;
  end

  assign found_o   = found_q;
  assign hit_idx_o = hit_idx_q;
  assign min_idx_o = min_idx_q;

endmodule

// ===== rtl/glyph_slot_cache_lru_unit.sv =====
// glyph slot cache, fully associative with least-recently-used replacement
// depends on gsc_pkg, gsc_ram, gsc_scan and glyph_slot_cache_lru_unit_defines.svh
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+-----------------------------------------
//  cfg      | in  | cfg_valid_i/cfg_ready_o| cfg_data_i: slots_in_use
//  s_axis   | in  | tvalid/tready          | tdata: char_code, tlast: last_in_string
//  m_axis   | out | tvalid/tready          | tdata: slot_index, hit, string_status,
//           |     |                        |        updated_count; tlast: string_done
//
// each transfer runs the states scan, drain and write: scan reads the active slots above slot zero
// from the slot ram one slot per cycle, drain lets the last registered read reach the scan unit,
// and write stores the entry back. the single ram read port forces the slot by slot scan.
// ready returns in the cycle after the write back, so no new character is taken mid-scan;
// the result register lets the next item start while a result waits, and write back
// stalls only while that register holds a result that is not taken.
// reset clears slot valid bits in flops, so no clearing pass runs after reset.
`include "glyph_slot_cache_lru_unit_defines.svh"

module glyph_slot_cache_lru_unit #(
  parameter int MAX_SLOTS = gsc_pkg::MAX_SLOTS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [gsc_pkg::CFG_W-1:0] cfg_data_i,      // [6:0] slots_in_use
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [15:0]               s_axis_tdata_i,  // [15:0] char_code
  input  logic                      s_axis_tlast_i,  // last_in_string
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [15:0]               m_axis_tdata_o,  // [5:0] slot_index, [6] hit,
                                                     // [7] string_status, [15:8] updated_count
  output logic                      m_axis_tlast_o   // string_done
);
  import gsc_pkg::*;

  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int CNT_W  = (SLOT_W + 1 > CFG_W) ? SLOT_W + 1 : CFG_W;
  localparam int RAM_W  = STAMP_W + CHAR_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [CFG_W-1:0]     slots_cfg_q;
  logic [CHAR_W-1:0]    ch_q;
  logic                 last_q;
  logic [SLOT_W-1:0]    last_idx_q;
  logic [SLOT_W-1:0]    addr_q, addr_d;
  logic                 rd_vld_q;
  logic [SLOT_W-1:0]    rd_idx_q;
  logic [MAX_SLOTS-1:0] slot_valid_q;
  logic [STAMP_W-1:0]   cur_stamp_q;
  logic [MISS_W-1:0]    miss_total_q;
  logic [COUNT_W-1:0]   upd_q;
  logic                 m_tvalid_q;
  logic [15:0]          m_tdata_q;
  logic                 m_tlast_q;

  logic                 in_xfer;
  logic                 commit;
  logic [CNT_W-1:0]     cfg_ext;
  logic [CNT_W-1:0]     n_act;
  logic [RAM_W-1:0]     ram_rdata;
  logic                 found;
  logic [SLOT_W-1:0]    hit_idx;
  logic [SLOT_W-1:0]    min_idx;
  logic [SLOT_W-1:0]    wr_slot;
  logic [COUNT_W-1:0]   upd_next;
  scan_ctrl_t           scan_ctrl;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign commit          = (state_q == ST_WRITE) && (!m_tvalid_q || m_axis_tready_i);

  // clamp the slot count into 2 .. MAX_SLOTS
  assign cfg_ext = CNT_W'(slots_cfg_q);
  always_comb begin
    if (cfg_ext < CNT_W'(2)) begin
      n_act = CNT_W'(2);
    end else if (cfg_ext > CNT_W'(MAX_SLOTS)) begin
      n_act = CNT_W'(MAX_SLOTS);
    end else begin
      n_act = cfg_ext;
    end
  end

  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_SCAN;
          addr_d  = SLOT_W'(1);
        end
      end
      ST_SCAN: begin
        if (addr_q == last_idx_q) begin
          state_d = ST_DRAIN;
        end else begin
          addr_d = addr_q + SLOT_W'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign scan_ctrl.start = in_xfer;
  assign scan_ctrl.step  = rd_vld_q;

  gsc_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (commit),
    .waddr_i (wr_slot),
    .wdata_i ({cur_stamp_q, ch_q}),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  gsc_scan #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (scan_ctrl),
    .idx_i         (rd_idx_q),
    .entry_valid_i (slot_valid_q[rd_idx_q]),
    .entry_char_i  (ram_rdata[CHAR_W-1:0]),
    .entry_stamp_i (ram_rdata[RAM_W-1:CHAR_W]),
    .key_i         (ch_q),
    .found_o       (found),
    .hit_idx_o     (hit_idx),
    .min_idx_o     (min_idx)
  );

  assign wr_slot  = found ? hit_idx : min_idx;
  assign upd_next = (found || upd_q == COUNT_MAX) ? upd_q : upd_q + COUNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      slots_cfg_q  <= SLOTS_RESET;
      rd_vld_q     <= 1'b0;
      slot_valid_q <= '0;
      cur_stamp_q  <= STAMP_RESET;
      miss_total_q <= '0;
      upd_q        <= '0;
      m_tvalid_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == ST_SCAN);
      if (cfg_valid_i && cfg_ready_o) begin
        slots_cfg_q <= cfg_data_i;
      end
      if (commit) begin
        slot_valid_q[wr_slot] <= 1'b1;
        m_tvalid_q            <= 1'b1;
        if (!found) begin
          miss_total_q <= miss_total_q + MISS_W'(1);
        end
        if (last_q) begin
          cur_stamp_q <= cur_stamp_q + STAMP_W'(1);
          upd_q       <= '0;
        end else begin
          upd_q <= upd_next;
        end
      end else if (m_axis_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    rd_idx_q <= addr_q;
    if (in_xfer) begin
      ch_q       <= s_axis_tdata_i[CHAR_W-1:0];
      last_q     <= s_axis_tlast_i;
      last_idx_q <= SLOT_W'(n_act - CNT_W'(1));
    end
    if (commit) begin
      m_tdata_q <= {upd_next, last_q && (upd_next != '0), found, OUT_SLOT_W'(wr_slot)};
      m_tlast_q <= last_q;
    end
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;
  assign m_axis_tlast_o  = m_tlast_q;

  // slot zero is never bound
  `GSC_ASSERT_SAME(a_no_slot_zero, commit, wr_slot != '0)
  // a hit always points at a bound slot
  `GSC_ASSERT_SAME(a_hit_bound, commit && found, slot_valid_q[hit_idx])
  // reads stay inside the active range
  `GSC_ASSERT_SAME(a_scan_range, rd_vld_q, rd_idx_q != '0 && rd_idx_q <= last_idx_q)
  // the stamp advances once per closed string
  `GSC_ASSERT_NEXT(a_stamp_step, commit && last_q, cur_stamp_q == $past(cur_stamp_q) + STAMP_W'(1))

endmodule
